>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/trrb_pkg.sv
`timescale 1ns / 1ps

package trrb_pkg;

  // Slot table
  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Coordinate mapping and fixed-point scales
  localparam int RAW_X_SPAN  = 19040;
  localparam int COORD_SCALE = 10;
  localparam int TRIG_SCALE  = 1000000;
  localparam int LIM_SCALE   = COORD_SCALE * TRIG_SCALE;

  // Datapath widths: offset, product, sum
  localparam int DIFF_W = 34;
  localparam int PROD_W = 55;
  localparam int SUM_W  = 56;

  // Channel widths
  localparam int CMD_W      = 3;
  localparam int VAL_W      = 32;
  localparam int TRANS_W    = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Event commands
  localparam logic [CMD_W-1:0] CMD_SLOT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POS_X = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POS_Y = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TRACK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OTHER = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z0_CX    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z0_CY    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Z1_CX    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z1_CY    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_COS  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_EXT = 4'd7;

  // Block transition codes
  localparam logic [TRANS_W-1:0] TR_NONE      = 2'd0;
  localparam logic [TRANS_W-1:0] TR_BLOCKED   = 2'd1;
  localparam logic [TRANS_W-1:0] TR_UNBLOCKED = 2'd2;

  // Tracking id that marks a lift
  localparam logic [VAL_W-1:0] TRACK_LIFT = '1;

endpackage

>>> rtl/core/trrb_ifs.sv
`timescale 1ns / 1ps

// Touch event request channel
interface trrb_event_if import trrb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] event_value;
  logic                    applies;

  modport source (output valid, command, event_value, applies, input ready);
  modport sink   (input valid, command, event_value, applies, output ready);
endinterface

// Filtered result channel
interface trrb_result_if import trrb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_out;
  logic                    forced_lift;
  logic [TRANS_W-1:0]      block_transition;

  modport source (output valid, value_out, forced_lift, block_transition, input ready);
  modport sink   (input valid, value_out, forced_lift, block_transition, output ready);
endinterface

// Register write channel
interface trrb_cfg_if import trrb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/touch_rotated_rect_blocker.sv
`timescale 1ns / 1ps
// Touch rotated-rectangle blocker.
// events  : multitouch absolute-axis requests (command, event_value, applies).
// results : one result per event (value_out, forced_lift, block_transition),
//           in event order; value_out is -1 when a touch-down lands in a zone.
// cfg     : register writes (index, data), ready whenever reset is low; write
//           only while the block is idle.
// Throughput: one event per cycle while results are taken. An event passes the
// three register stages around the eight rotation multipliers (offset,
// product, compare) before its result is presented.
// Slot select and position writes update the slot table in the cycle the
// request is taken, so the next event sees them at once; the blocked flags
// update as results enter the output register, in event order.
// Reset (rst, synchronous) loads the register defaults, clears the slot
// table, blocked flags and current slot, and empties the pipeline; no
// requests or register writes are taken while it is high.
// When the receiver stalls the result register holds; stages behind it fill
// up, and events are refused only once every stage is occupied.
`include "assert_macros.svh"

module touch_rotated_rect_blocker import trrb_pkg::*; (
  input logic          clk,
  input logic          rst,
  trrb_event_if.sink   events,
  trrb_result_if.source results,
  trrb_cfg_if.sink     cfg
);

  // Configuration registers
  logic                  enable;
  logic [11:0]           zone0_cx;
  logic [10:0]           zone0_cy;
  logic [11:0]           zone1_cx;
  logic [10:0]           zone1_cy;
  logic signed [20:0]    rot_cos;
  logic signed [20:0]    rot_sin;
  logic [23:0]           half_ext;

  // Slot state
  logic [SLOT_W-1:0]       active_slot;
  logic signed [VAL_W-1:0] slot_raw_x [NUM_SLOTS];
  logic signed [VAL_W-1:0] slot_raw_y [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    blocked_flags;

  // Stage 1: offsets from each centre
  logic                     s1_valid;
  logic                     s1_test;
  logic signed [VAL_W-1:0]  s1_value;
  logic [SLOT_W-1:0]        s1_slot;
  logic signed [DIFF_W-1:0] s1_dx0, s1_dy0, s1_dx1, s1_dy1;

  // Stage 2: rotation products
  logic                     s2_valid;
  logic                     s2_test;
  logic signed [VAL_W-1:0]  s2_value;
  logic [SLOT_W-1:0]        s2_slot;
  logic signed [PROD_W-1:0] s2_ua0, s2_ub0, s2_va0, s2_vb0;
  logic signed [PROD_W-1:0] s2_ua1, s2_ub1, s2_va1, s2_vb1;

  // Output register
  logic                    out_valid;
  logic signed [VAL_W-1:0] value_out;
  logic                    forced_lift;
  logic [TRANS_W-1:0]      block_trans;

  // Handshake chain
  logic ev_take, s1_move, s2_move, s1_free, s2_free, out_free;

  assign out_free = !out_valid || results.ready;
  assign s2_move  = s2_valid && out_free;
  assign s2_free  = !s2_valid || s2_move;
  assign s1_move  = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s1_move;
  assign events.ready = s1_free && !rst;
  assign ev_take  = events.valid && events.ready;
  assign cfg.ready = !rst;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b1;
      zone0_cx <= 12'd2757;
      zone0_cy <= 11'd1228;
      zone1_cx <= 12'd2841;
      zone1_cy <= 11'd1218;
      rot_cos  <= 21'sd342020;
      rot_sin  <= 21'sd939693;
      half_ext <= 24'd82110;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE:   enable   <= cfg.data[0];
        REG_Z0_CX:    zone0_cx <= cfg.data[11:0];
        REG_Z0_CY:    zone0_cy <= cfg.data[10:0];
        REG_Z1_CX:    zone1_cx <= cfg.data[11:0];
        REG_Z1_CY:    zone1_cy <= cfg.data[10:0];
        REG_ROT_COS:  rot_cos  <= $signed(cfg.data[20:0]);
        REG_ROT_SIN:  rot_sin  <= $signed(cfg.data[20:0]);
        REG_HALF_EXT: half_ext <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front end: decode, slot clamp, table read
  logic                     act;
  logic [SLOT_W-1:0]        cur_slot;
  logic [SLOT_W-1:0]        slot_next;
  logic signed [DIFF_W-1:0] sx, sy;
  logic signed [DIFF_W-1:0] cx0_s, cy0_s, cx1_s, cy1_s;
  logic                     is_test;

  assign act = events.applies && enable;
  assign cur_slot = (active_slot < NUM_SLOTS) ? active_slot : SLOT_W'(NUM_SLOTS - 1);

  always_comb begin
    if (events.event_value < 0)
      slot_next = '0;
    else if (events.event_value >= NUM_SLOTS)
      slot_next = SLOT_W'(NUM_SLOTS - 1);
    else
      slot_next = events.event_value[SLOT_W-1:0];
  end

  // sx = rawY, sy = span - rawX, centres scaled by ten
  assign sx    = DIFF_W'(slot_raw_y[cur_slot]);
  assign sy    = DIFF_W'(RAW_X_SPAN) - DIFF_W'(slot_raw_x[cur_slot]);
  assign cx0_s = $signed(DIFF_W'(zone0_cx) * DIFF_W'(COORD_SCALE));
  assign cy0_s = $signed(DIFF_W'(zone0_cy) * DIFF_W'(COORD_SCALE));
  assign cx1_s = $signed(DIFF_W'(zone1_cx) * DIFF_W'(COORD_SCALE));
  assign cy1_s = $signed(DIFF_W'(zone1_cy) * DIFF_W'(COORD_SCALE));
  assign is_test = act && (events.command == CMD_TRACK) && (events.event_value != TRACK_LIFT);

  // Slot table and current slot update at request time
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slot <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_raw_x[i] <= '0;
        slot_raw_y[i] <= '0;
      end
    end else if (ev_take && act) begin
      case (events.command)
        CMD_SLOT:  active_slot          <= slot_next;
        CMD_POS_X: slot_raw_x[cur_slot] <= events.event_value;
        CMD_POS_Y: slot_raw_y[cur_slot] <= events.event_value;
        default: ;
      endcase
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (s1_free) s1_valid <= events.valid;
  end

  always_ff @(posedge clk) begin
    if (ev_take) begin
      s1_test  <= is_test;
      s1_value <= events.event_value;
      s1_slot  <= cur_slot;
      s1_dx0   <= sx - cx0_s;
      s1_dy0   <= sy - cy0_s;
      s1_dx1   <= sx - cx1_s;
      s1_dy1   <= sy - cy1_s;
    end
  end

  // Stage 2 register: eight parallel products
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (s2_free) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_test  <= s1_test;
      s2_value <= s1_value;
      s2_slot  <= s1_slot;
      s2_ua0   <= PROD_W'(s1_dx0) * PROD_W'(rot_cos);
      s2_ub0   <= PROD_W'(s1_dy0) * PROD_W'(rot_sin);
      s2_va0   <= PROD_W'(s1_dy0) * PROD_W'(rot_cos);
      s2_vb0   <= PROD_W'(s1_dx0) * PROD_W'(rot_sin);
      s2_ua1   <= PROD_W'(s1_dx1) * PROD_W'(rot_cos);
      s2_ub1   <= PROD_W'(s1_dy1) * PROD_W'(rot_sin);
      s2_va1   <= PROD_W'(s1_dy1) * PROD_W'(rot_cos);
      s2_vb1   <= PROD_W'(s1_dx1) * PROD_W'(rot_sin);
    end
  end

  // Rotated coordinates and strict bounds test
  logic signed [SUM_W-1:0] u0, v0, u1, v1, ul, vl;
  logic                    in0, in1, hit, was_blocked;

  assign u0 = SUM_W'(s2_ua0) + SUM_W'(s2_ub0);
  assign v0 = SUM_W'(s2_va0) - SUM_W'(s2_vb0);
  assign u1 = SUM_W'(s2_ua1) + SUM_W'(s2_ub1);
  assign v1 = SUM_W'(s2_va1) - SUM_W'(s2_vb1);
  assign ul = $signed(SUM_W'(half_ext[11:0]) * SUM_W'(LIM_SCALE));
  assign vl = $signed(SUM_W'(half_ext[23:12]) * SUM_W'(LIM_SCALE));
  assign in0 = (u0 > -ul) && (u0 < ul) && (v0 > -vl) && (v0 < vl);
  assign in1 = (u1 > -ul) && (u1 < ul) && (v1 > -vl) && (v1 < vl);
  assign hit = s2_test && (in0 || in1);
  assign was_blocked = blocked_flags[s2_slot];

  // Output register and blocked flags, in event order
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_free) out_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_flags <= '0;
    end else if (s2_move && s2_test) begin
      blocked_flags[s2_slot] <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      value_out   <= hit ? $signed(TRACK_LIFT) : s2_value;
      forced_lift <= hit;
      if (s2_test && hit && !was_blocked)
        block_trans <= TR_BLOCKED;
      else if (s2_test && !hit && was_blocked)
        block_trans <= TR_UNBLOCKED;
      else
        block_trans <= TR_NONE;
    end
  end

  assign results.valid            = out_valid;
  assign results.value_out        = value_out;
  assign results.forced_lift      = forced_lift;
  assign results.block_transition = block_trans;

  // Checks
  `ASSERT_SYNC(a_slot_range, clk, rst, active_slot < NUM_SLOTS, "current slot out of range")
  `ASSERT_SYNC(a_flag_hold, clk, rst, !s2_move |=> $stable(blocked_flags), "blocked flag moved without a result")
  `ASSERT_SYNC(a_trans_lift, clk, rst, out_valid && (block_trans == TR_BLOCKED) |-> forced_lift && (value_out == -1), "newly blocked slot without forced lift")
  `ASSERT_SYNC(a_unblock_nolift, clk, rst, out_valid && (block_trans == TR_UNBLOCKED) |-> !forced_lift, "unblocked slot reported with forced lift")
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !s1_valid && !s2_valid && !out_valid, "pipeline not empty after reset")

endmodule
